@@ sv/multi_channel_escalating_watchdog_macros.svh @@
// Assertion macros shared by the watchdog modules.
`ifndef MULTI_CHANNEL_ESCALATING_WATCHDOG_MACROS_SVH
`define MULTI_CHANNEL_ESCALATING_WATCHDOG_MACROS_SVH

// Checked only while reset is released.
`define MCEW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, also during reset.
`define MCEW_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/mcew_pkg.sv @@
// Types, codes and constants of the multi-channel escalating watchdog.
package mcew_pkg;

	localparam int TIME_W  = 32;
	localparam int LIMIT_W = 16;
	localparam int CFG_AW  = 4;
	localparam int CFG_DW  = 32;

	localparam logic [LIMIT_W-1:0] SESSION_LIMIT_RST = 16'd30000;
	localparam logic [LIMIT_W-1:0] LISTEN_LIMIT_RST  = 16'd12000;
	localparam logic [LIMIT_W-1:0] GRACE_RST         = 16'd5000;
	localparam logic [LIMIT_W-1:0] BEAT_LIMIT_RST    = 16'd15000;

	// Register indexes, i.e. byte address bits [3:2].
	localparam logic [1:0] REG_SESSION = 2'd0;
	localparam logic [1:0] REG_LISTEN  = 2'd1;
	localparam logic [1:0] REG_GRACE   = 2'd2;
	localparam logic [1:0] REG_BEAT    = 2'd3;

	localparam logic [1:0] STAGE_LISTEN = 2'd1;
	localparam logic [1:0] STAGE_EXEC   = 2'd2;

	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_CANCEL  = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	localparam logic [2:0] CAUSE_NONE     = 3'd0;
	localparam logic [2:0] CAUSE_AUDIO    = 3'd1;
	localparam logic [2:0] CAUSE_SPEECH   = 3'd2;
	localparam logic [2:0] CAUSE_PRESENCE = 3'd3;
	localparam logic [2:0] CAUSE_UI       = 3'd4;
	localparam logic [2:0] CAUSE_LISTEN   = 3'd5;
	localparam logic [2:0] CAUSE_SESSION  = 3'd6;
	localparam logic [2:0] CAUSE_EXEC     = 3'd7;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] audio_beat_ms;
		logic [TIME_W-1:0] speech_beat_ms;
		logic [TIME_W-1:0] presence_beat_ms;
		logic [TIME_W-1:0] ui_stalled_ms;
		logic              awake;
		logic [TIME_W-1:0] awake_since_ms;
		logic [TIME_W-1:0] progress_ms;
		logic [1:0]        stage;
		logic              clear_pending;
	} in_item_t;

	typedef struct packed {
		logic [1:0] action;
		logic [2:0] cause;
	} out_item_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] session_limit_ms;
		logic [LIMIT_W-1:0] listen_stall_limit_ms;
		logic [LIMIT_W-1:0] cancel_grace_ms;
		logic [LIMIT_W-1:0] beat_limit_ms;
	} cfg_t;

endpackage

@@ sv/mcew_cfg.sv @@
// APB register file holding the four watchdog limits.
module mcew_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mcew_pkg::CFG_AW-1:2]  paddr,
	input  logic [mcew_pkg::CFG_DW-1:0]  pwdata,
	output logic [mcew_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready,
	output mcew_pkg::cfg_t               cfg
);
	import mcew_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [LIMIT_W-1:0] rd_val;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.session_limit_ms      <= SESSION_LIMIT_RST;
			cfg_q.listen_stall_limit_ms <= LISTEN_LIMIT_RST;
			cfg_q.cancel_grace_ms       <= GRACE_RST;
			cfg_q.beat_limit_ms         <= BEAT_LIMIT_RST;
		end else if (wr_en) begin
			case (paddr)
				REG_SESSION: cfg_q.session_limit_ms      <= pwdata[LIMIT_W-1:0];
				REG_LISTEN:  cfg_q.listen_stall_limit_ms <= pwdata[LIMIT_W-1:0];
				REG_GRACE:   cfg_q.cancel_grace_ms       <= pwdata[LIMIT_W-1:0];
				REG_BEAT:    cfg_q.beat_limit_ms         <= pwdata[LIMIT_W-1:0];
				default:     cfg_q.beat_limit_ms         <= cfg_q.beat_limit_ms;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			REG_SESSION: rd_val = cfg_q.session_limit_ms;
			REG_LISTEN:  rd_val = cfg_q.listen_stall_limit_ms;
			REG_GRACE:   rd_val = cfg_q.cancel_grace_ms;
			REG_BEAT:    rd_val = cfg_q.beat_limit_ms;
			default:     rd_val = '0;
		endcase
	end

	assign prdata = {{(CFG_DW-LIMIT_W){1'b0}}, rd_val};
	assign cfg    = cfg_q;

endmodule

@@ sv/mcew_check.sv @@
// Priority checks of one poll and the cancel grace state.
module mcew_check (
	input  logic                clk,
	input  logic                arst_n,
	input  mcew_pkg::cfg_t      cfg,
	input  mcew_pkg::in_item_t  item,
	input  logic                commit,
	output mcew_pkg::out_item_t result
);
	import mcew_pkg::*;
	`include "multi_channel_escalating_watchdog_macros.svh"

	logic              armed_q;
	logic [TIME_W-1:0] armed_at_q;

	logic [TIME_W-1:0] el_audio, el_speech, el_presence, el_progress, el_session, el_armed;
	logic [TIME_W-1:0] beat_lim, listen_lim, session_lim, grace_lim;
	logic stale_audio, stale_speech, stale_presence, ui_stall;
	logic session_on, listen_stall, session_over, grace_left, armed_eff;

	assign beat_lim    = TIME_W'(cfg.beat_limit_ms);
	assign listen_lim  = TIME_W'(cfg.listen_stall_limit_ms);
	assign session_lim = TIME_W'(cfg.session_limit_ms);
	assign grace_lim   = TIME_W'(cfg.cancel_grace_ms);

	// Elapsed times wrap with the millisecond counter.
	assign el_audio    = item.now_ms - item.audio_beat_ms;
	assign el_speech   = item.now_ms - item.speech_beat_ms;
	assign el_presence = item.now_ms - item.presence_beat_ms;
	assign el_progress = item.now_ms - item.progress_ms;
	assign el_session  = item.now_ms - item.awake_since_ms;
	assign el_armed    = item.now_ms - armed_at_q;

	assign stale_audio    = (item.audio_beat_ms != '0) && (el_audio >= beat_lim);
	assign stale_speech   = (item.stage != STAGE_EXEC) && (item.speech_beat_ms != '0)
	                        && (el_speech >= beat_lim);
	assign stale_presence = (item.presence_beat_ms != '0) && (el_presence >= beat_lim);
	assign ui_stall       = item.ui_stalled_ms >= beat_lim;
	assign session_on     = item.awake && (item.awake_since_ms != '0);
	assign listen_stall   = (item.stage == STAGE_LISTEN) && (item.progress_ms != '0)
	                        && (el_progress >= listen_lim);
	assign session_over   = el_session >= session_lim;
	assign grace_left     = el_armed < grace_lim;
	assign armed_eff      = armed_q && !item.clear_pending;

	always_comb begin
		result.action = ACT_NONE;
		result.cause  = CAUSE_NONE;
		if (stale_audio) begin
			result = '{ACT_RESTART, CAUSE_AUDIO};
		end else if (stale_speech) begin
			result = '{ACT_RESTART, CAUSE_SPEECH};
		end else if (stale_presence) begin
			result = '{ACT_RESTART, CAUSE_PRESENCE};
		end else if (ui_stall) begin
			result = '{ACT_RESTART, CAUSE_UI};
		end else if (session_on) begin
			if (listen_stall) begin
				result = '{ACT_RESTART, CAUSE_LISTEN};
			end else if (session_over) begin
				if (item.stage != STAGE_EXEC) begin
					result = '{ACT_RESTART, CAUSE_SESSION};
				end else if (!armed_eff) begin
					result = '{ACT_CANCEL, CAUSE_SESSION};
				end else if (!grace_left) begin
					result = '{ACT_RESTART, CAUSE_EXEC};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q    <= 1'b0;
			armed_at_q <= '0;
		end else if (commit) begin
			if (result.action == ACT_RESTART) begin
				armed_q    <= 1'b0;
				armed_at_q <= '0;
			end else if (result.action == ACT_CANCEL) begin
				armed_q    <= 1'b1;
				armed_at_q <= item.now_ms;
			end else begin
				armed_q    <= armed_eff;
			end
		end
	end

	`MCEW_ASSERT(a_restart_disarms, commit && result.action == ACT_RESTART |=> !armed_q && armed_at_q == '0, "restart left the grace timer armed")
	`MCEW_ASSERT(a_cancel_arms, commit && result.action == ACT_CANCEL |=> armed_q && armed_at_q == $past(item.now_ms), "cancel did not arm the grace timer")
	`MCEW_ASSERT(a_cancel_exec_only, result.action == ACT_CANCEL |-> item.stage == STAGE_EXEC && !armed_eff, "cancel outside an unarmed executing stage")
	`MCEW_ASSERT_ALWAYS(a_no_action_no_cause, result.action == ACT_NONE |-> result.cause == CAUSE_NONE, "cause given without action")

endmodule

@@ sv/multi_channel_escalating_watchdog.sv @@
// Top level of the multi-channel escalating watchdog: input and result registers.
//
//  channel  | signals                                      | moves
//  ---------+----------------------------------------------+----------------------------
//  poll in  | in_valid, in_stall, in_item                  | one poll per transaction
//  result   | out_valid, out_stall, out_item               | one action and cause each
//  config   | psel, penable, pwrite, paddr, pwdata, prdata | 16-bit limits at 4*i
//
// A poll is captured in the input register; its result is written to the output register,
// raising out_valid, once that register is empty or being drained.
// One poll per cycle is sustained while the output is not stalled; the grace timer
// updates as each result is registered, so the following poll already sees it.
// A stalled result holds; the input register still takes one more poll behind it.
// Reset restores the limits to their defaults and disarms the grace timer.
module multi_channel_escalating_watchdog (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  mcew_pkg::in_item_t           in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output mcew_pkg::out_item_t          out_item,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mcew_pkg::CFG_AW-1:2]  paddr,
	input  logic [mcew_pkg::CFG_DW-1:0]  pwdata,
	output logic [mcew_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready
);
	import mcew_pkg::*;
	`include "multi_channel_escalating_watchdog_macros.svh"

	cfg_t      cfg;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	out_item_t result;
	logic      advance;
	logic      commit;

	mcew_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// The output register can take a new result when it is empty or being drained.
	assign advance  = !out_valid_q || !out_stall;
	assign commit   = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	mcew_check u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.commit (commit),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`MCEW_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> valid_s1, "input stalled with an empty input register")
	`MCEW_ASSERT(a_held_poll_kept, valid_s1 && out_valid_q && out_stall |=> valid_s1 && out_valid_q, "poll or result dropped while the output was stalled")
	`MCEW_ASSERT(a_commit_fills_out, commit |=> out_valid_q, "committed result not presented")

endmodule
